// ===== rtl/core/srcomp_pkg.sv =====
// Shared types, codes and helpers for the sensor reading compensation block.
// Used by the serial multiplier, the serial divider and the top level.
`default_nettype none
package srcomp_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CntW  = 5;

  typedef logic [WordW-1:0] word_t;

  // quantity codes of an input item
  localparam logic [1:0] OP_TEMP  = 2'd0;
  localparam logic [1:0] OP_PRESS = 2'd1;
  localparam logic [1:0] OP_HUMID = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_TEMP    = 3'd0;
  localparam logic [2:0] REG_PRESS_A = 3'd1;
  localparam logic [2:0] REG_PRESS_B = 3'd2;
  localparam logic [2:0] REG_PRESS_C = 3'd3;
  localparam logic [2:0] REG_HUMID   = 3'd4;

  // control of one iterative unit
  typedef struct packed {
    logic  go;
    word_t a;
    word_t b;
  } unit_req_t;

  // arithmetic right shift of a 32-bit pattern
  function automatic word_t asr(input word_t x, input logic [4:0] n);
    asr = word_t'($signed(x) >>> n);
  endfunction

  function automatic word_t sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  function automatic word_t sx12(input logic [11:0] v);
    sx12 = {{20{v[11]}}, v};
  endfunction

  function automatic word_t sx8(input logic [7:0] v);
    sx8 = {{24{v[7]}}, v};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sensor_reading_compensation_top.sv =====
// Sensor reading compensation: a step sequencer drives a bit-serial multiplier
// and a bit-serial divider. Items are handled one at a time; a new item is
// taken only once the result of the last is registered, and later while
// out_stall_i holds a waiting result. Reset clears the configuration
// registers, fine temperature and control; payload registers are not reset.
`default_nettype none
module sensor_reading_compensation_top import srcomp_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  op_i,
  input  wire  [19:0] raw_sample_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [31:0] value_o,
  output logic        divide_fault_o,
  input  wire         cfg_we_i,
  input  wire  [2:0]  cfg_idx_i,
  input  wire  [63:0] cfg_data_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RUN   = 3'd1;
  localparam logic [2:0] ST_MWAIT = 3'd2;
  localparam logic [2:0] ST_DWAIT = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [3:0]  step_q, step_d;
  logic [1:0]  op_q;
  word_t       rw_q;
  word_t       ft_q, ft_d;
  word_t       ra_q, ra_d, rb_q, rb_d, rc_q, rc_d, rd_q, rd_d;
  logic        flag_q, flag_d;
  word_t       res_q, res_d;
  logic        flt_q, flt_d;
  logic        out_valid_q;
  word_t       value_q;
  logic        fault_q;
  logic [47:0] tc_q, pa_q, pb_q, pc_q;
  logic [63:0] hc_q;

  unit_req_t mreq, dreq;
  logic      mul_busy, mul_done, div_busy, div_done;
  word_t     m, dq;

  srcomp_mul u_mul (
    .clk_i, .rst_ni, .req_i(mreq), .busy_o(mul_busy), .done_o(mul_done), .p_o(m)
  );
  srcomp_div u_div (
    .clk_i, .rst_ni, .req_i(dreq), .busy_o(div_busy), .done_o(div_done), .q_o(dq)
  );

  // coefficient fields
  word_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  word_t h1, h2, h3, h4, h5, h6;
  assign t1 = {16'd0, tc_q[15:0]};
  assign t2 = sx16(tc_q[31:16]);
  assign t3 = sx16(tc_q[47:32]);
  assign p1 = {16'd0, pa_q[15:0]};
  assign p2 = sx16(pa_q[31:16]);
  assign p3 = sx16(pa_q[47:32]);
  assign p4 = sx16(pb_q[15:0]);
  assign p5 = sx16(pb_q[31:16]);
  assign p6 = sx16(pb_q[47:32]);
  assign p7 = sx16(pc_q[15:0]);
  assign p8 = sx16(pc_q[31:16]);
  assign p9 = sx16(pc_q[47:32]);
  assign h1 = {24'd0, hc_q[7:0]};
  assign h2 = sx16(hc_q[23:8]);
  assign h3 = {24'd0, hc_q[31:24]};
  assign h4 = sx12(hc_q[43:32]);
  assign h5 = sx12(hc_q[55:44]);
  assign h6 = sx8(hc_q[63:56]);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= '0;
      pa_q <= '0;
      pb_q <= '0;
      pc_q <= '0;
      hc_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TEMP:    tc_q <= cfg_data_i[47:0];
        REG_PRESS_A: pa_q <= cfg_data_i[47:0];
        REG_PRESS_B: pb_q <= cfg_data_i[47:0];
        REG_PRESS_C: pc_q <= cfg_data_i[47:0];
        REG_HUMID:   hc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // step sequencer
  word_t tmp, hx, v1c;
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    ft_d    = ft_q;
    ra_d    = ra_q;
    rb_d    = rb_q;
    rc_d    = rc_q;
    rd_d    = rd_q;
    flag_d  = flag_q;
    res_d   = res_q;
    flt_d   = flt_q;
    mreq    = '0;
    dreq    = '0;
    tmp     = '0;
    hx      = ft_q - 32'd76800;
    v1c     = asr(ft_q, 5'd1) - 32'd64000;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RUN;
          step_d  = '0;
          flt_d   = 1'b0;
          res_d   = '0;
        end
      end
      ST_RUN: begin
        // launch a multiply (a divide at pressure step 7) and wait, unless the step finishes the item
        state_d = ST_MWAIT;
        step_d  = step_q + 1'b1;
        mreq.go = 1'b1;
        case (op_q)
          OP_TEMP: begin
            case (step_q)
              4'd0: begin
                mreq.a = (rw_q >> 3) - (t1 << 1);
                mreq.b = t2;
              end
              4'd1: begin
                ra_d   = asr(m, 5'd11);
                mreq.a = (rw_q >> 4) - t1;
                mreq.b = (rw_q >> 4) - t1;
              end
              4'd2: begin
                mreq.a = asr(m, 5'd12);
                mreq.b = t3;
              end
              4'd3: begin
                tmp    = ra_q + asr(m, 5'd14);
                ft_d   = tmp;
                mreq.a = tmp;
                mreq.b = 32'd5;
              end
              default: begin
                mreq.go = 1'b0;
                res_d   = asr(m + 32'd128, 5'd8);
                state_d = ST_DONE;
              end
            endcase
          end
          OP_PRESS: begin
            case (step_q)
              4'd0: begin
                ra_d   = v1c;
                mreq.a = asr(v1c, 5'd2);
                mreq.b = asr(v1c, 5'd2);
              end
              4'd1: begin
                rc_d   = m;
                mreq.a = asr(m, 5'd11);
                mreq.b = p6;
              end
              4'd2: begin
                rd_d   = m;
                mreq.a = ra_q;
                mreq.b = p5;
              end
              4'd3: begin
                rd_d   = asr(rd_q + (m << 1), 5'd2) + (p4 << 16);
                mreq.a = p3;
                mreq.b = asr(rc_q, 5'd13);
              end
              4'd4: begin
                rb_d   = asr(m, 5'd3);
                mreq.a = p2;
                mreq.b = ra_q;
              end
              4'd5: begin
                mreq.a = 32'd32768 + asr(rb_q + asr(m, 5'd1), 5'd18);
                mreq.b = p1;
              end
              4'd6: begin
                tmp  = asr(m, 5'd15);
                ra_d = tmp;
                if (tmp == '0) begin
                  mreq.go = 1'b0;
                  flt_d   = 1'b1;
                  res_d   = '0;
                  state_d = ST_DONE;
                end else begin
                  mreq.a = (32'd1048576 - rw_q) - asr(rd_q, 5'd12);
                  mreq.b = 32'd3125;
                end
              end
              4'd7: begin
                // divide the doubled value; when doubling would overflow, divide it as is and double the quotient
                mreq.go = 1'b0;
                flag_d  = m[31];
                dreq.go = 1'b1;
                dreq.a  = m[31] ? m : (m << 1);
                dreq.b  = ra_q;
                state_d = ST_DWAIT;
              end
              4'd8: begin
                tmp    = flag_q ? (dq << 1) : dq;
                rc_d   = tmp;
                mreq.a = tmp >> 3;
                mreq.b = tmp >> 3;
              end
              4'd9: begin
                mreq.a = p9;
                mreq.b = m >> 13;
              end
              4'd10: begin
                ra_d   = asr(m, 5'd12);
                mreq.a = rc_q >> 2;
                mreq.b = p8;
              end
              default: begin
                mreq.go = 1'b0;
                res_d   = rc_q + asr(ra_q + asr(m, 5'd13) + p7, 5'd4);
                state_d = ST_DONE;
              end
            endcase
          end
          OP_HUMID: begin
            case (step_q)
              4'd0: begin
                mreq.a = h5;
                mreq.b = hx;
              end
              4'd1: begin
                ra_d   = asr((rw_q << 14) - (h4 << 20) - m + 32'd16384, 5'd15);
                mreq.a = hx;
                mreq.b = h6;
              end
              4'd2: begin
                rb_d   = asr(m, 5'd10);
                mreq.a = hx;
                mreq.b = h3;
              end
              4'd3: begin
                mreq.a = rb_q;
                mreq.b = asr(m, 5'd11) + 32'd32768;
              end
              4'd4: begin
                mreq.a = asr(m, 5'd10) + 32'd2097152;
                mreq.b = h2;
              end
              4'd5: begin
                mreq.a = ra_q;
                mreq.b = asr(m + 32'd8192, 5'd14);
              end
              4'd6: begin
                rc_d   = m;
                mreq.a = asr(m, 5'd15);
                mreq.b = asr(m, 5'd15);
              end
              4'd7: begin
                mreq.a = asr(m, 5'd7);
                mreq.b = h1;
              end
              default: begin
                // clamp to 0..100 percent before scaling
                mreq.go = 1'b0;
                tmp     = rc_q - asr(m, 5'd4);
                if (tmp[31]) tmp = '0;
                if (tmp > 32'd419430400) tmp = 32'd419430400;
                res_d   = tmp >> 12;
                state_d = ST_DONE;
              end
            endcase
          end
          default: begin
            mreq.go = 1'b0;
            res_d   = '0;
            state_d = ST_DONE;
          end
        endcase
      end
      ST_MWAIT: begin
        if (mul_done) state_d = ST_RUN;
      end
      ST_DWAIT: begin
        if (div_done) state_d = ST_RUN;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      ft_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      ft_q    <= ft_d;
      if (state_q == ST_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ra_q   <= ra_d;
    rb_q   <= rb_d;
    rc_q   <= rc_d;
    rd_q   <= rd_d;
    flag_q <= flag_d;
    res_q  <= res_d;
    flt_q  <= flt_d;
    if (state_q == ST_IDLE && in_valid_i) begin
      op_q <= op_i;
      rw_q <= {12'd0, raw_sample_i};
    end
    if (state_q == ST_DONE && (!out_valid_q || !out_stall_i)) begin
      value_q <= res_q;
      fault_q <= flt_q;
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign value_o        = value_q;
  assign divide_fault_o = fault_q;

`ifndef ASSERT_OFF
  a_idle_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> (!mul_busy && !div_busy))
    else $error("unit busy while idle");
  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({mul_busy, div_busy}))
    else $error("multiplier and divider busy together");
  a_div_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dreq.go |-> (op_q == OP_PRESS && dreq.b != '0))
    else $error("divide outside pressure or by zero");
  a_fault_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && flt_q) |-> (op_q == OP_PRESS && res_q == '0))
    else $error("fault on non-pressure item");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/srcomp_mul.sv =====
// Bit-serial 32x32 multiplier keeping the low 32 product bits.
// Depends on srcomp_pkg; one multiplier bit per cycle over all 32 multiplier bits.
`default_nettype none
module srcomp_mul import srcomp_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  unit_req_t req_i,
  output logic      busy_o,
  output logic      done_o,
  output word_t     p_o
);

  word_t          a_q, b_q, acc_q;
  logic [CntW-1:0] cnt_q;
  logic           busy_q, done_q;

  // control: count the bits of one product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.go) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(WordW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: add the shifted multiplicand for each set multiplier bit
  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      if (b_q[0]) acc_q <= acc_q + a_q;
      a_q <= {a_q[WordW-2:0], 1'b0};
      b_q <= {1'b0, b_q[WordW-1:1]};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule
`default_nettype wire

// ===== rtl/core/srcomp_div.sv =====
// Restoring unsigned 32/32 divider, one quotient bit per cycle.
// Depends on srcomp_pkg; a = dividend, b = nonzero divisor.
`default_nettype none
module srcomp_div import srcomp_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  unit_req_t req_i,
  output logic      busy_o,
  output logic      done_o,
  output word_t     q_o
);

  word_t           rem_q, quo_q, den_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [WordW:0]  shifted;
  logic            ge;

  assign shifted = {rem_q, quo_q[WordW-1]};
  assign ge      = shifted >= {1'b0, den_q};

  // control: count the quotient bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.go) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(WordW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: shift in one dividend bit, subtract when it fits
  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      rem_q <= '0;
      quo_q <= req_i.a;
      den_q <= req_i.b;
    end else if (busy_q) begin
      rem_q <= ge ? word_t'(shifted - {1'b0, den_q}) : shifted[WordW-1:0];
      quo_q <= {quo_q[WordW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign q_o    = quo_q;

endmodule
`default_nettype wire
